[sv/rrc_pi_pkg.sv]
package rrc_pi_pkg;

  // Field widths
  localparam int VALUE_W   = 16;
  localparam int INDEX_W   = 8;
  localparam int SAMPLE_W  = 36;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 2 * VALUE_W;

  // Per-phase counters and tap address walker (p + k*m stays below 512)
  localparam int CNT_W     = 5;
  localparam int TADDR_W   = 10;

  // Outputs per symbol never exceed this
  localparam int RESULT_LIMIT = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UP_FACTOR    = 2'd0,
    CFG_SPAN_SYMBOLS = 2'd1,
    CFG_SHAPE_MODE   = 2'd2
  } cfg_idx_t;

  // Input opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TAP  = 1'b1;

  // Pulse shapes
  localparam logic SHAPE_RRC  = 1'b0;
  localparam logic SHAPE_RECT = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] UP_RESET   = 5'd8;
  localparam logic [CFG_W-1:0] SPAN_RESET = 5'd8;

  // Saturation bounds of the sample
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

endpackage

[sv/rrc_pi_ram.sv]
module rrc_pi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/rrc_pulse_shaping_interpolator_top.sv]
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_opcode, in_tap_index, in_value
// out      output     out_valid/out_ready  out_sample, out_last
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A tap write completes in the idle state. A symbol push in RRC mode runs, per output phase,
// span_symbols tap/history reads, a drain through the read and multiply registers
// and an emit step, for each of the up_factor phases; the single multiply-accumulate
// unit fed by the two memories sets this pace. Rect mode emits up_factor samples
// straight from the held symbol, with no reads. The next item is taken once the last
// sample has moved to the output register. A stalled output holds the engine
// in its emit step. Reset clears control state and the history fill count.
module rrc_pulse_shaping_interpolator_top #(
  parameter int MAX_TAPS = 256,
  parameter int MAX_SPAN = 16,
  parameter int MAX_UP   = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_opcode,
  input  logic [rrc_pi_pkg::INDEX_W-1:0]          in_tap_index,
  input  logic signed [rrc_pi_pkg::VALUE_W-1:0]   in_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [rrc_pi_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                    out_last,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [rrc_pi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rrc_pi_pkg::CFG_W-1:0]            cfg_data
);

  import rrc_pi_pkg::*;

  localparam int TAW    = $clog2(MAX_TAPS);
  localparam int HW     = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
  localparam int HDEPTH = 2 ** HW;
  localparam int UP_LIM = (MAX_UP < RESULT_LIMIT) ? MAX_UP : RESULT_LIMIT;
  localparam int ACC_W  = (PROD_W + HW + 1 > SAMPLE_W + 1) ? PROD_W + HW + 1 : SAMPLE_W + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [CFG_W-1:0] up_r, span_r;
  logic             shape_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r    <= UP_RESET;
      span_r  <= SPAN_RESET;
      shape_r <= SHAPE_RRC;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_UP_FACTOR:    up_r    <= cfg_data;
        CFG_SPAN_SYMBOLS: span_r  <= cfg_data;
        CFG_SHAPE_MODE:   shape_r <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // Effective (clamped) up factor and span
  logic [CNT_W-1:0] m_eff, span_eff;

  always_comb begin
    m_eff = up_r;
    if (up_r == '0) m_eff = CNT_W'(1);
    else if (7'(up_r) > 7'(UP_LIM)) m_eff = CNT_W'(UP_LIM);
    span_eff = span_r;
    if (span_r == '0) span_eff = CNT_W'(1);
    else if (7'(span_r) > 7'(MAX_SPAN)) span_eff = CNT_W'(MAX_SPAN);
  end

  // Engine registers
  logic [CNT_W-1:0]        ph_r, ph_nxt;
  logic [CNT_W-1:0]        k_r, k_nxt;
  logic [TADDR_W-1:0]      t_r, t_nxt;
  logic [HW-1:0]           head_r, head_nxt;
  logic [HW:0]             cnt_r, cnt_nxt;
  logic signed [VALUE_W-1:0] sym_r, sym_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  // Read pipeline: stage 1 = RAM data returning, stage 2 = product registered
  logic                    s1_v_r, s1_zero_r, s1_last_r;
  logic                    s2_v_r, s2_last_r;
  logic signed [PROD_W-1:0] prod_r;

  // Output register
  logic                    out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                    out_last_r;

  logic in_xfer, out_load, ph_last, issue;
  logic tap_we, hist_we;
  logic [VALUE_W-1:0] tap_rd, hist_rd;
  logic [HW-1:0] hist_rd_addr;
  logic signed [SAMPLE_W-1:0] sat_sample, emit_sample;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign ph_last  = (ph_r == m_eff - CNT_W'(1));
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign issue    = (state_r == S_MAC);

  assign tap_we  = in_xfer && (in_opcode == OP_TAP) && (11'(in_tap_index) < 11'(MAX_TAPS));
  assign hist_we = in_xfer && (in_opcode == OP_PUSH);

  assign hist_rd_addr = head_r - HW'(k_r);

  // Coefficient store
  rrc_pi_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_TAPS)) u_tap_ram (
    .clk     (clk),
    .wr_en   (tap_we),
    .wr_addr (TAW'(in_tap_index)),
    .wr_data (in_value),
    .rd_addr (t_r[TAW-1:0]),
    .rd_data (tap_rd)
  );

  // Symbol history ring, newest entry at head
  rrc_pi_ram #(.WIDTH(VALUE_W), .DEPTH(HDEPTH)) u_hist_ram (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (head_r + HW'(1)),
    .wr_data (in_value),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_rd)
  );

  // Saturate accumulator to the sample range; rect mode emits the held symbol scaled by 2^15 instead
  always_comb begin
    if (acc_r[ACC_W-1:SAMPLE_W-1] == '0 || acc_r[ACC_W-1:SAMPLE_W-1] == '1) begin
      sat_sample = acc_r[SAMPLE_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      sat_sample = SAMPLE_MIN;
    end else begin
      sat_sample = SAMPLE_MAX;
    end
    if (shape_r == SHAPE_RECT) begin
      emit_sample = {{(SAMPLE_W-VALUE_W-15){sym_r[VALUE_W-1]}}, sym_r, 15'd0};
    end else begin
      emit_sample = sat_sample;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    k_nxt     = k_r;
    t_nxt     = t_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    sym_nxt   = sym_r;
    acc_nxt   = acc_r;
    if (s2_v_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
    case (state_r)
      S_IDLE: begin
        if (hist_we) begin
          head_nxt = head_r + HW'(1);
          if (cnt_r != (HW+1)'(HDEPTH)) cnt_nxt = cnt_r + (HW+1)'(1);
          sym_nxt  = in_value;
          ph_nxt   = '0;
          k_nxt    = '0;
          t_nxt    = '0;
          acc_nxt  = '0;
          state_nxt = (shape_r == SHAPE_RECT) ? S_EMIT : S_MAC;
        end
      end
      S_MAC: begin
        k_nxt = k_r + CNT_W'(1);
        t_nxt = t_r + TADDR_W'(m_eff);
        if (k_r == span_eff - CNT_W'(1)) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (s2_v_r && s2_last_r) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          if (ph_last) begin
            state_nxt = S_IDLE;
          end else begin
            ph_nxt = ph_r + CNT_W'(1);
            if (shape_r != SHAPE_RECT) begin
              k_nxt     = '0;
              t_nxt     = TADDR_W'(ph_r) + TADDR_W'(1);
              acc_nxt   = '0;
              state_nxt = S_MAC;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload and datapath
  always_ff @(posedge clk) begin
    ph_r  <= ph_nxt;
    k_r   <= k_nxt;
    t_r   <= t_nxt;
    sym_r <= sym_nxt;
    acc_r <= acc_nxt;
    // Term is zero for a tap beyond the store or a history slot never filled
    s1_zero_r <= !(11'(t_r) < 11'(MAX_TAPS)) || !(7'(k_r) < 7'(cnt_r));
    s1_last_r <= (k_r == span_eff - CNT_W'(1));
    s2_last_r <= s1_last_r;
    prod_r    <= s1_zero_r ? $signed(PROD_W'(0)) : $signed(hist_rd) * $signed(tap_rd);
    if (out_load) begin
      out_sample_r <= emit_sample;
      out_last_r   <= ph_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

  // Checks
  a_k_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (k_r < span_eff))
    else $error("term counter beyond span");

  a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> s2_v_r)
    else $error("read pipeline lost a term");

  a_drain_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s2_last_r) |=> (state_r == S_EMIT))
    else $error("finished phase did not reach emit");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (HW+1)'(HDEPTH))
    else $error("history fill count overrun");

endmodule

[sim/rrc_pulse_shaping_interpolator_top_tb.sv]
`timescale 1ns / 1ps

module rrc_pulse_shaping_interpolator_top_tb;
  import rrc_pi_pkg::*;

  localparam int TAP_DEPTH     = 256;
  localparam int HIST_DEPTH    = 16;
  localparam int UP_LIMIT      = 16;
  localparam int SPAN_LIMIT    = 16;
  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One shaped output sample
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } shaped_t;

  logic                         clk;
  logic                         rst_n        = 1'b0;
  logic                         in_valid     = 1'b0;
  logic                         in_ready;
  logic                         in_opcode    = OP_PUSH;
  logic [INDEX_W-1:0]           in_tap_index = '0;
  logic signed [VALUE_W-1:0]    in_value     = '0;
  logic                         out_valid;
  logic                         out_ready    = 1'b0;
  logic signed [SAMPLE_W-1:0]   out_sample;
  logic                         out_last;
  logic                         cfg_valid    = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index    = '0;
  logic [CFG_W-1:0]             cfg_data     = '0;

  // Shadow state of the shaper
  logic signed [VALUE_W-1:0] coef_mem [TAP_DEPTH];
  bit                        coef_loaded [TAP_DEPTH];
  logic signed [VALUE_W-1:0] sym_hist [HIST_DEPTH];
  logic [CFG_W-1:0]          up_reg;
  logic [CFG_W-1:0]          span_reg;
  logic                      mode_reg;

  shaped_t sample_q [$];
  shaped_t want;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int error_count  = 0;
  int symbols_pushed, taps_written, cfg_writes, samples_checked;
  int stall_cycles = 0;

  rrc_pulse_shaping_interpolator_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_tap_index (in_tap_index),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shaper prediction
  // ---------------------------------------------------------------------------

  // Register values outside 1..16 are clamped
  function automatic int eff_up();
    int m;
    m = up_reg;
    if (m < 1) m = 1;
    if (m > UP_LIMIT) m = UP_LIMIT;
    if (m > RESULT_LIMIT) m = RESULT_LIMIT;
    return m;
  endfunction

  function automatic int eff_span();
    int s;
    s = span_reg;
    if (s < 1) s = 1;
    if (s > SPAN_LIMIT) s = SPAN_LIMIT;
    return s;
  endfunction

  // Shift a symbol into the history and queue its up_factor samples
  function automatic void shape_symbol(input logic signed [VALUE_W-1:0] sym);
    int      m, span, p, k, i, t;
    longint  acc;
    shaped_t smp;
    for (i = HIST_DEPTH - 1; i > 0; i--) sym_hist[i] = sym_hist[i-1];
    sym_hist[0] = sym;
    m    = eff_up();
    span = eff_span();
    for (p = 0; p < m; p++) begin
      acc = 0;
      if (mode_reg == SHAPE_RECT) begin
        acc = longint'(sym) * 32768;
      end else begin
        for (k = 0; k < span; k++) begin
          t = p + k * m;
          if (t < TAP_DEPTH) acc += longint'(sym_hist[k]) * longint'(coef_mem[t]);
        end
      end
      if (acc > longint'(SAMPLE_MAX)) acc = longint'(SAMPLE_MAX);
      if (acc < longint'(SAMPLE_MIN)) acc = longint'(SAMPLE_MIN);
      smp.sample = acc[SAMPLE_W-1:0];
      smp.last   = (p == m - 1);
      sample_q.push_back(smp);
    end
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks; each is entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // One input transfer; valid stays high on exit so back-to-back items need no gap
  task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] val);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_tap_index <= idx;
    in_value     <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_TAP) begin
      coef_mem[idx]    = val;
      coef_loaded[idx] = 1'b1;
      taps_written++;
    end else begin
      shape_symbol(val);
      symbols_pushed++;
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= reg_idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (reg_idx)
      CFG_UP_FACTOR:    up_reg   = data;
      CFG_SPAN_SYMBOLS: span_reg = data;
      CFG_SHAPE_MODE:   mode_reg = data[0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  // Every tap the current setting can read must hold a written value first
  task automatic load_missing_taps();
    int need, i;
    need = eff_up() * eff_span();
    for (i = 0; i < need; i++)
      if (!coef_loaded[i]) send_item(OP_TAP, INDEX_W'(i), rand_value());
  endtask

  // Upper data bits of shape_mode are don't-care and get random values
  task automatic set_config(input logic [CFG_W-1:0] up, input logic [CFG_W-1:0] span,
                            input logic mode);
    write_reg(CFG_UP_FACTOR, up);
    write_reg(CFG_SPAN_SYMBOLS, span);
    write_reg(CFG_SHAPE_MODE, {4'($urandom), mode});
    cfg_valid <= 1'b0;
    load_missing_taps();
  endtask

  // Drop valid, let every outstanding sample drain, then allow a tap write to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sample_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset setting (8 x 8): symbol extremes, push ignores tap_index, tap rewrites
  task automatic test_reset_setting();
    load_missing_taps();
    send_item(OP_PUSH, 8'h00, 16'sh7FFF);
    send_item(OP_PUSH, 8'hFF, 16'sh8000);
    send_item(OP_PUSH, 8'hA5, 16'sh0000);
    send_item(OP_TAP,  8'h00, 16'sh8000);
    send_item(OP_TAP,  8'h3F, 16'sh7FFF);
    send_item(OP_PUSH, 8'h5A, 16'sh0001);
    send_item(OP_PUSH, 8'hFF, 16'shFFFF);
    send_item(OP_PUSH, 8'h00, 16'sh8000);
  endtask

  // Rectangular hold keeps feeding the history, so RRC resumes seamlessly
  task automatic test_rect_hold();
    wait_idle();
    set_config(5'd4, 5'd3, SHAPE_RECT);
    send_item(OP_PUSH, 8'h12, 16'sh7FFF);
    send_item(OP_PUSH, 8'h34, 16'sh8000);
    send_item(OP_PUSH, 8'h56, 16'sh0123);
    wait_idle();
    set_config(5'd4, 5'd3, SHAPE_RRC);
    send_item(OP_PUSH, 8'h78, -16'sd300);
  endtask

  // Zero and oversized registers are clamped; the unused register index is ignored
  task automatic test_config_limits();
    wait_idle();
    set_config(5'd0, 5'd0, SHAPE_RRC);
    send_item(OP_PUSH, 8'h00, 16'sh4000);
    send_item(OP_PUSH, 8'h00, 16'shC000);
    wait_idle();
    set_config(5'd31, 5'd4, SHAPE_RRC);
    send_item(OP_TAP,  8'h3F, 16'sh8000);
    send_item(OP_PUSH, 8'h00, 16'sh8000);
    send_item(OP_PUSH, 8'h00, 16'sh7FFF);
    wait_idle();
    write_reg(CFG_UNUSED, 5'h1F);
    set_config(5'd3, 5'd31, SHAPE_RRC);
    send_item(OP_PUSH, 8'h00, rand_value());
    wait_idle();
    set_config(5'd16, 5'd1, SHAPE_RRC);
    send_item(OP_PUSH, 8'h00, 16'sh8000);
  endtask

  // Segments of random traffic, each under a freshly drawn setting;
  // mostly small sizes, a few large up factors and some out-of-range values
  task automatic test_random_traffic(input int n_items);
    int   sent, seg_len, r, j;
    logic [CFG_W-1:0] up, span;
    logic mode;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      r = $urandom_range(99);
      if (r < 8) begin
        up      = CFG_W'($urandom_range(12, 31));
        span    = CFG_W'($urandom_range(2, 4));
        seg_len = 3;
      end else if (r < 25) begin
        up      = CFG_W'($urandom_range(0, 31));
        span    = CFG_W'($urandom_range(0, 3));
        seg_len = $urandom_range(4, 10);
      end else begin
        up      = CFG_W'($urandom_range(1, 6));
        span    = CFG_W'($urandom_range(1, 6));
        seg_len = $urandom_range(8, 16);
      end
      mode = ($urandom_range(99) < 20) ? SHAPE_RECT : SHAPE_RRC;
      set_config(up, span, mode);
      for (j = 0; j < seg_len; j++) begin
        if ($urandom_range(99) < 15)
          send_item(OP_TAP, INDEX_W'($urandom_range(255)), rand_value());
        else
          send_item(OP_PUSH, INDEX_W'($urandom), rand_value());
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  always @(negedge clk) out_ready <= ($urandom_range(99) >= out_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (sample_q.size() == 0) begin
        $error("unexpected out transfer: sample=%0d last=%0b", out_sample, out_last);
        error_count++;
      end else begin
        want = sample_q.pop_front();
        samples_checked++;
        if (want.sample !== out_sample) begin
          $error("sample mismatch: expected %0d, actual %0d", $signed(want.sample), out_sample);
          error_count++;
        end
        if (want.last !== out_last) begin
          $error("last mismatch: expected %0b, actual %0b", want.last, out_last);
          error_count++;
        end
      end
    end
  end

  // Ends the run if no channel completes a transfer for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    int i;
    for (i = 0; i < HIST_DEPTH; i++) sym_hist[i] = '0;
    for (i = 0; i < TAP_DEPTH; i++) begin
      coef_mem[i]    = '0;
      coef_loaded[i] = 1'b0;
    end
    up_reg   = UP_RESET;
    span_reg = SPAN_RESET;
    mode_reg = SHAPE_RRC;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    in_idle_pct  = 24;
    out_idle_pct = 46;
    test_reset_setting();
    test_rect_hold();
    test_config_limits();
    test_random_traffic(46);

    in_idle_pct  = 46;
    out_idle_pct = 24;
    test_random_traffic(46);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_traffic(46);

    wait_idle();
    $display("Run covered %0d symbols, %0d tap writes and %0d register writes",
             symbols_pushed, taps_written, cfg_writes);
    $display("%0d samples checked over RRC and rectangular shapes, clamped settings",
             samples_checked);
    if (error_count == 0 && sample_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
